@@ rtl/cakf_pkg.sv @@
// Shared types, constants and helpers for the constant-acceleration Kalman filter.
package cakf_pkg;

	localparam int VALUE_W     = 32;
	localparam int COV_FRAC    = 24;
	localparam int DT_FRAC     = 16;
	localparam int DT_W        = 20;
	localparam int HDT_W       = 24;
	localparam int NOISE_W     = 31;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 32;
	localparam int MEM_DEPTH   = 27;
	localparam int ADDR_W      = 5;
	localparam int FP_BASE     = 9;
	localparam int PP_BASE     = 18;
	localparam int P_ENTRIES   = 9;
	localparam int OPND_W      = 33;
	localparam int PROD_W      = 66;
	localparam int ADD_W       = 34;
	localparam int ACC_W       = 52;
	localparam int QUOT_W      = 32;
	localparam int REM_W       = 57;
	localparam int DIV_W       = 64;
	localparam int IT_W        = 5;
	localparam int IN_TDATA_W  = 120;
	localparam int OUT_TDATA_W = 96;

	localparam logic [NOISE_W-1:0] NOISE_POS_RST  = 31'd335544;
	localparam logic [NOISE_W-1:0] NOISE_VEL_RST  = 31'd2516582;
	localparam logic [NOISE_W-1:0] NOISE_ACC_RST  = 31'd13421773;
	localparam logic [NOISE_W-1:0] NOISE_MEAS_RST = 31'd5872026;

	localparam logic [CFG_IDX_W-1:0] REG_NOISE_POS  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_VEL  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_ACC  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_MEAS = 4'd3;

	localparam logic [VALUE_W-1:0] COV_ONE = 32'h0100_0000;
	localparam logic signed [OPND_W-1:0] F_ONE = 33'sh0_0001_0000;
	localparam logic signed [ACC_W-1:0] SAT_HI = 52'sh0_0000_7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] SAT_LO = 52'shF_FFFF_8000_0000;

	typedef enum logic {OP_UPDATE = 1'b0, OP_RESET = 1'b1} opcode_t;

	typedef enum logic [1:0] {SH_DT, SH_HALF, SH_COV} shift_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HDT, ST_XP, ST_FP, ST_PP, ST_SRD, ST_SUM,
		ST_DRD, ST_DINIT, ST_DIT, ST_DFIN, ST_XU, ST_PU, ST_OUT
	} state_t;

	typedef struct packed {
		logic       valid;
		state_t     phase;
		logic [1:0] r;
		logic [1:0] c;
		logic [1:0] j;
		logic       first;
		logic       last;
	} mac_ctl_t;

	// base + 3*r + c
	function automatic logic [ADDR_W-1:0] mat_addr(input logic [ADDR_W-1:0] base,
			input logic [1:0] r, input logic [1:0] c);
		mat_addr = base + {2'b0, r, 1'b0} + {3'b0, r} + {3'b0, c};
	endfunction

	// transition matrix entry, Q.16
	function automatic logic signed [OPND_W-1:0] f_entry(input logic [1:0] r,
			input logic [1:0] c, input logic [DT_W-1:0] dt, input logic [HDT_W-1:0] hdt2);
		logic [1:0] rn;
		rn = r + 2'd1;
		if (r == c)
			f_entry = F_ONE;
		else if (c == rn)
			f_entry = $signed({13'b0, dt});
		else if (r == 2'd0 && c == 2'd2)
			f_entry = $signed({9'b0, hdt2});
		else
			f_entry = '0;
	endfunction

	function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v > SAT_HI)
			sat32 = SAT_HI[VALUE_W-1:0];
		else if (v < SAT_LO)
			sat32 = SAT_LO[VALUE_W-1:0];
		else
			sat32 = v[VALUE_W-1:0];
	endfunction

endpackage

@@ rtl/const_accel_kalman_filter.sv @@
// An update item skips the gain divider when innovation variance <= 0.
// Throughput: one item at a time; the single MAC (one term per cycle, 76 terms) and
// the bit-serial divider (three 32-step quotients) set the update time.
// Covariance, F*P and predicted P sit in one 27-entry memory with registered reads.
// Reset: async active low; estimates zero, covariance identity via per-entry valid
// bits (no clearing pass), noise registers at their defaults, output empty.
module const_accel_kalman_filter import cakf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// meas_or_start_pos[31:0], time_step[51:32], start_velocity[83:52],
	// start_accel[115:84], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// opcode[0]
	input  logic [0:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// est_position[31:0], est_velocity[63:32], est_accel[95:64]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// control
	state_t state_q, state_d;
	logic [1:0] r_q, c_q, j_q;
	logic done_q;
	logic [1:0] rmax, cmax, jmax;
	logic mac_state, issue, last_term, phase_done, out_load, s_acc;

	// configuration
	logic [NOISE_W-1:0] noise_q [4];

	// filter registers
	logic signed [VALUE_W-1:0] x_q [3];
	logic signed [VALUE_W-1:0] xp_q [3];
	logic signed [VALUE_W-1:0] k_q [3];
	logic signed [VALUE_W-1:0] meas_q;
	logic [DT_W-1:0] dt_q;
	logic [HDT_W-1:0] hdt2_q;
	logic signed [VALUE_W:0] innov;

	// state memory: P at 0, F*P at FP_BASE, predicted P at PP_BASE
	logic [VALUE_W-1:0] mem_q [MEM_DEPTH];
	logic [VALUE_W-1:0] rda_q, rdb_q, rda_val;
	logic [ADDR_W-1:0] ra, rb, ra_s1, mem_wa;
	logic mem_we;
	logic [P_ENTRIES-1:0] pvalid_q;

	// MAC pipeline
	mac_ctl_t ctl_s0, ctl_s1, ctl_s2;
	logic signed [OPND_W-1:0] opa, opb;
	logic signed [ADD_W-1:0] add_s1, add_s2;
	shift_t sh_s1, sh_s2;
	logic signed [PROD_W-1:0] prod, prod_s2;
	logic [PROD_W-1:0] mag, rnd;
	logic neg;
	logic signed [ACC_W-1:0] term, sum, acc_q;
	logic signed [VALUE_W-1:0] sum_sat;

	// divider
	logic signed [ADD_W-1:0] s_sum;
	logic s_pos;
	logic [QUOT_W:0] s_q;
	logic [REM_W-1:0] rem_q, un;
	logic [DIV_W-1:0] dvs_q;
	logic [QUOT_W-1:0] q_q, pp_mag;
	logic [IT_W-1:0] it_q;
	logic ovf_q, dneg_q, ge;
	logic signed [VALUE_W-1:0] kval;

	// output register
	logic m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign innov     = {meas_q[VALUE_W-1], meas_q} - {xp_q[0][VALUE_W-1], xp_q[0]};

	// ---------------- term counters per phase ----------------
	always_comb begin
		mac_state = 1'b1;
		rmax = 2'd2; cmax = 2'd2; jmax = 2'd2;
		unique case (state_q)
			ST_HDT: begin rmax = 2'd0; cmax = 2'd0; jmax = 2'd0; end
			ST_XP:  cmax = 2'd0;
			ST_FP, ST_PP: ;
			ST_XU:  begin cmax = 2'd0; jmax = 2'd0; end
			ST_PU:  jmax = 2'd0;
			default: mac_state = 1'b0;
		endcase
	end

	assign issue      = mac_state && !done_q;
	assign last_term  = (r_q == rmax) && (c_q == cmax) && (j_q == jmax);
	assign phase_done = mac_state && done_q && !ctl_s1.valid && !ctl_s2.valid;

	assign s_sum = $signed({{2{rda_q[VALUE_W-1]}}, rda_q}) + $signed({3'b0, noise_q[3]});
	assign s_pos = !s_sum[ADD_W-1] && (s_sum != '0);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_acc) state_d = (opcode_t'(s_tuser[0]) == OP_RESET) ? ST_OUT : ST_HDT;
			ST_HDT:   if (phase_done) state_d = ST_XP;
			ST_XP:    if (phase_done) state_d = ST_FP;
			ST_FP:    if (phase_done) state_d = ST_PP;
			ST_PP:    if (phase_done) state_d = ST_SRD;
			ST_SRD:   state_d = ST_SUM;
			ST_SUM:   state_d = s_pos ? ST_DRD : ST_XU;
			ST_DRD:   state_d = ST_DINIT;
			ST_DINIT: state_d = ST_DIT;
			ST_DIT:   if (it_q == '0) state_d = ST_DFIN;
			ST_DFIN:  state_d = (r_q == 2'd2) ? ST_XU : ST_DRD;
			ST_XU:    if (phase_done) state_d = ST_PU;
			ST_PU:    if (phase_done) state_d = ST_OUT;
			ST_OUT:   if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ---------------- read addresses (issue stage) ----------------
	always_comb begin
		ra = '0;
		rb = '0;
		unique case (state_q)
			ST_FP:  ra = mat_addr('0, j_q, c_q);
			ST_PP:  ra = mat_addr(ADDR_W'(FP_BASE), r_q, j_q);
			ST_PU:  begin
				ra = mat_addr(ADDR_W'(PP_BASE), 2'd0, c_q);
				rb = mat_addr(ADDR_W'(PP_BASE), r_q, c_q);
			end
			ST_SRD: ra = ADDR_W'(PP_BASE);
			ST_DRD: ra = mat_addr(ADDR_W'(PP_BASE), r_q, 2'd0);
			default: ;
		endcase
	end

	always_comb begin
		ctl_s0.valid = issue;
		ctl_s0.phase = state_q;
		ctl_s0.r     = r_q;
		ctl_s0.c     = c_q;
		ctl_s0.j     = j_q;
		ctl_s0.first = (j_q == 2'd0);
		ctl_s0.last  = (j_q == jmax);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0; c_q <= '0; j_q <= '0; done_q <= 1'b0;
		end else if (state_q == ST_DFIN && state_d == ST_DRD) begin
			r_q <= r_q + 2'd1;
		end else if (state_d != state_q &&
				(state_q == ST_SUM || state_d == ST_HDT || state_d == ST_XP ||
				 state_d == ST_FP || state_d == ST_PP || state_d == ST_XU ||
				 state_d == ST_PU)) begin
			r_q <= '0; c_q <= '0; j_q <= '0; done_q <= 1'b0;
		end else if (issue) begin
			done_q <= last_term;
			if (j_q != jmax) begin
				j_q <= j_q + 2'd1;
			end else begin
				j_q <= '0;
				if (c_q != cmax) begin
					c_q <= c_q + 2'd1;
				end else begin
					c_q <= '0;
					r_q <= r_q + 2'd1;
				end
			end
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q[0] <= NOISE_POS_RST;
			noise_q[1] <= NOISE_VEL_RST;
			noise_q[2] <= NOISE_ACC_RST;
			noise_q[3] <= NOISE_MEAS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NOISE_POS:  noise_q[0] <= cfg_data[NOISE_W-1:0];
				REG_NOISE_VEL:  noise_q[1] <= cfg_data[NOISE_W-1:0];
				REG_NOISE_ACC:  noise_q[2] <= cfg_data[NOISE_W-1:0];
				REG_NOISE_MEAS: noise_q[3] <= cfg_data[NOISE_W-1:0];
				default: ; // out of range: dropped
			endcase
		end
	end

	// ---------------- state memory ----------------
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_wa] <= sum_sat;
		rda_q <= mem_q[ra];
		rdb_q <= mem_q[rb];
		ra_s1 <= ra;
	end

	// P entries never written since reset (or a reset item) read as identity
	always_comb begin
		rda_val = rda_q;
		if (ra_s1 < ADDR_W'(P_ENTRIES) && !pvalid_q[ra_s1[3:0]])
			rda_val = (ra_s1 == 5'd0 || ra_s1 == 5'd4 || ra_s1 == 5'd8) ? COV_ONE : '0;
	end

	// ---------------- MAC stage 1: operand select and multiply ----------------
	always_comb begin
		opa    = '0;
		opb    = '0;
		add_s1 = '0;
		sh_s1  = SH_DT;
		case (ctl_s1.phase)
			ST_HDT: begin
				opa   = $signed({13'b0, dt_q});
				opb   = $signed({13'b0, dt_q});
				sh_s1 = SH_HALF;
			end
			ST_XP: begin
				opa = f_entry(ctl_s1.r, ctl_s1.j, dt_q, hdt2_q);
				opb = {x_q[ctl_s1.j][VALUE_W-1], x_q[ctl_s1.j]};
			end
			ST_FP: begin
				opa = f_entry(ctl_s1.r, ctl_s1.j, dt_q, hdt2_q);
				opb = $signed({rda_val[VALUE_W-1], rda_val});
			end
			ST_PP: begin
				opa = $signed({rda_val[VALUE_W-1], rda_val});
				opb = f_entry(ctl_s1.c, ctl_s1.j, dt_q, hdt2_q);
				if (ctl_s1.r == ctl_s1.c)
					add_s1 = $signed({3'b0, noise_q[ctl_s1.r]});
			end
			ST_XU: begin
				opa    = {k_q[ctl_s1.r][VALUE_W-1], k_q[ctl_s1.r]};
				opb    = innov;
				add_s1 = {{2{xp_q[ctl_s1.r][VALUE_W-1]}}, xp_q[ctl_s1.r]};
				sh_s1  = SH_COV;
			end
			ST_PU: begin
				// P = pp - k*pp0, folded as (-k)*pp0 + pp
				opa    = -{k_q[ctl_s1.r][VALUE_W-1], k_q[ctl_s1.r]};
				opb    = $signed({rda_val[VALUE_W-1], rda_val});
				add_s1 = $signed({{2{rdb_q[VALUE_W-1]}}, rdb_q});
				sh_s1  = SH_COV;
			end
			default: ;
		endcase
	end

	assign prod = opa * opb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod;
		add_s2  <= add_s1;
		sh_s2   <= sh_s1;
	end

	// ---------------- MAC stage 2: round half away, accumulate, saturate ----------------
	always_comb begin
		neg = prod_s2[PROD_W-1];
		mag = neg ? PROD_W'(-prod_s2) : PROD_W'(prod_s2);
		case (sh_s2)
			SH_DT:   rnd = (mag + (PROD_W'(1) << (DT_FRAC - 1))) >> DT_FRAC;
			SH_HALF: rnd = (mag + (PROD_W'(1) << DT_FRAC)) >> (DT_FRAC + 1);
			SH_COV:  rnd = (mag + (PROD_W'(1) << (COV_FRAC - 1))) >> COV_FRAC;
			default: rnd = '0;
		endcase
		term    = neg ? -$signed(rnd[ACC_W-1:0]) : $signed(rnd[ACC_W-1:0]);
		sum     = (ctl_s2.first ? ACC_W'(add_s2) : acc_q) + term;
		sum_sat = sat32(sum);
	end

	assign mem_we = ctl_s2.valid && ctl_s2.last &&
		(ctl_s2.phase == ST_FP || ctl_s2.phase == ST_PP || ctl_s2.phase == ST_PU);

	always_comb begin
		mem_wa = mat_addr('0, ctl_s2.r, ctl_s2.c);
		if (ctl_s2.phase == ST_FP)
			mem_wa = mat_addr(ADDR_W'(FP_BASE), ctl_s2.r, ctl_s2.c);
		else if (ctl_s2.phase == ST_PP)
			mem_wa = mat_addr(ADDR_W'(PP_BASE), ctl_s2.r, ctl_s2.c);
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid && !ctl_s2.last)
			acc_q <= sum;
		if (ctl_s2.valid && ctl_s2.last) begin
			if (ctl_s2.phase == ST_HDT)
				hdt2_q <= sum[HDT_W-1:0];
			if (ctl_s2.phase == ST_XP)
				xp_q[ctl_s2.r] <= sum_sat;
		end
		if (s_acc) begin
			meas_q <= s_tdata[31:0];
			dt_q   <= s_tdata[51:32];
		end
	end

	// estimates and P valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q[0] <= '0; x_q[1] <= '0; x_q[2] <= '0;
			pvalid_q <= '0;
		end else begin
			if (s_acc && opcode_t'(s_tuser[0]) == OP_RESET) begin
				x_q[0]   <= s_tdata[31:0];
				x_q[1]   <= s_tdata[83:52];
				x_q[2]   <= s_tdata[115:84];
				pvalid_q <= '0;
			end
			if (ctl_s2.valid && ctl_s2.last && ctl_s2.phase == ST_XU)
				x_q[ctl_s2.r] <= sum_sat;
			if (mem_we && ctl_s2.phase == ST_PU)
				pvalid_q[mem_wa[3:0]] <= 1'b1;
		end
	end

	// ---------------- gain divider: k = round(pp[r][0] * 2^24 / s) ----------------
	assign pp_mag = rda_q[VALUE_W-1] ? QUOT_W'(-rda_q) : rda_q;
	assign un     = (REM_W'(pp_mag) << COV_FRAC) + REM_W'(s_q >> 1);
	assign ge     = DIV_W'(rem_q) >= dvs_q;

	always_comb begin
		if (!dneg_q)
			kval = (ovf_q || q_q[QUOT_W-1]) ? SAT_HI[VALUE_W-1:0] : q_q;
		else if (ovf_q || (q_q[QUOT_W-1] && q_q[QUOT_W-2:0] != '0))
			kval = SAT_LO[VALUE_W-1:0];
		else
			kval = -q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
		end else if (state_q == ST_DINIT) begin
			it_q <= IT_W'(QUOT_W - 1);
		end else if (state_q == ST_DIT) begin
			it_q <= it_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SUM: begin
				s_q <= s_sum[QUOT_W:0];
				if (!s_pos) begin
					k_q[0] <= '0; k_q[1] <= '0; k_q[2] <= '0;
				end
			end
			ST_DINIT: begin
				dneg_q <= rda_q[VALUE_W-1];
				ovf_q  <= DIV_W'(un) >= (DIV_W'(s_q) << QUOT_W);
				rem_q  <= un;
				dvs_q  <= DIV_W'(s_q) << (QUOT_W - 1);
				q_q    <= '0;
			end
			ST_DIT: begin
				if (ge)
					rem_q <= REM_W'(DIV_W'(rem_q) - dvs_q);
				q_q   <= {q_q[QUOT_W-2:0], ge};
				dvs_q <= dvs_q >> 1;
			end
			ST_DFIN: k_q[r_q] <= kval;
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_tdata_q <= {x_q[2], x_q[1], x_q[0]};
	end

`ifndef ASSERT_OFF
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!ctl_s1.valid && !ctl_s2.valid))
		else $error("MAC pipeline busy while idle");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIT) |-> (s_q != '0))
		else $error("divide with zero innovation variance");

	a_update_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser[0]) |=> (state_q == ST_HDT))
		else $error("update transfer did not start prediction");
`endif

endmodule
